// File: hdl/doi_pkg.sv
// Shared types, constants and register codes for the disc obstacle inflation unit.
`default_nettype none
package doi_pkg;

    // Default map size and radius limits
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_RADIUS = 6;

    // Cost byte codes
    localparam logic [7:0] COST_INSCRIBED = 8'd253;
    localparam logic [7:0] COST_LETHAL    = 8'd254;
    localparam logic [7:0] COST_UNKNOWN   = 8'd255;

    // Register reset values
    localparam int RST_WIDTH  = 1024;
    localparam int RST_HEIGHT = 1024;
    localparam int RST_RADIUS = 3;
    localparam int RST_LEVEL  = 253;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INFLATE_RADIUS = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INFLATE_LEVEL  = 4'd3;

    // Input command codes
    localparam logic CMD_CELL  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] cell_cost;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_cost;
        logic       frame_last;
    } out_word_t;

endpackage
`default_nettype wire

// File: hdl/disc_obstacle_inflation_unit.sv
// Top level of the disc obstacle inflation unit: registers, counters and result stage.
`default_nettype none
// Takes one occupancy-grid cost word per clock in raster order and returns one inflated cost
// word per clock, R*W+R cells behind the input (W = map_width, R = inflate_radius); flush
// words (cmd = 1) drain the pending cells one per word, treating cells not yet received as
// non-lethal. Sustained rate is one word per clock: the line store memories are read once
// per clock for the next column word and the next cost, and a result is in the output
// register in the cycle after the input word that causes it is accepted. Input stalls only
// while that register holds a result the receiver has not yet taken. Writing map_width,
// map_height or inflate_radius drops pending cells and restarts the frame; inflate_level
// acts at once.
// The line store holds (2*MAX_RADIUS+2)*MAX_WIDTH cost bytes and MAX_WIDTH column words of
// lethal bits; it needs no clearing pass, since only cells received in the current frame
// are ever used.
module disc_obstacle_inflation_unit #(
    parameter int MAX_WIDTH  = doi_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = doi_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = doi_pkg::DEF_MAX_RADIUS
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire doi_pkg::in_word_t                 s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output doi_pkg::out_word_t                     m_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [doi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [doi_pkg::CFG_DATA_W-1:0]    cfg_data
);
    localparam int NS  = 2*MAX_RADIUS+2;
    localparam int WB  = $clog2(MAX_WIDTH+1);
    localparam int CB  = $clog2(MAX_WIDTH);
    localparam int HB  = $clog2(MAX_HEIGHT+1);
    localparam int RB  = $clog2(MAX_RADIUS+1);
    localparam int SB  = $clog2(NS);
    localparam int PB  = $clog2(MAX_WIDTH*MAX_HEIGHT+1);
    localparam int DB  = $clog2(MAX_RADIUS*MAX_WIDTH+MAX_RADIUS+1);
    localparam int QB  = ((PB > DB) ? PB : DB) + 1;
    localparam int W_RST = (doi_pkg::RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : doi_pkg::RST_WIDTH;
    localparam int H_RST = (doi_pkg::RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT
                                                               : doi_pkg::RST_HEIGHT;
    localparam int R_RST = (doi_pkg::RST_RADIUS > MAX_RADIUS) ? MAX_RADIUS
                                                               : doi_pkg::RST_RADIUS;

    // configuration
    logic [WB-1:0] w_reg, w_next;
    logic [HB-1:0] h_reg, h_next;
    logic [RB-1:0] r_reg, r_next;
    logic [7:0]    lvl_reg, lvl_next;
    logic [DB-1:0] delay_reg, delay_next;
    logic          cfg_wr, cfg_geom;

    // position counters
    logic [CB-1:0] in_col_reg, in_col_next, in_col_adv;
    logic [HB-1:0] in_row_reg, in_row_next, in_row_adv;
    logic [SB-1:0] in_slot_reg, in_slot_next, in_slot_adv;
    logic [PB-1:0] rcv_reg, rcv_next;
    logic [CB-1:0] out_col_reg, out_col_next;
    logic [HB-1:0] out_row_reg, out_row_next;
    logic [SB-1:0] out_slot_reg, out_slot_next;
    logic [PB-1:0] out_cnt_reg, out_cnt_next;

    // result stage
    logic               m_valid_reg, m_valid_next;
    doi_pkg::out_word_t m_data_reg, m_data_next;

    logic          accept, wr_en, emit, last, clear, hit;
    logic [7:0]    cost_q, cost_p, result;
    logic [NS-1:0] pf_word;
    logic [CB-1:0] rd_col;

    assign cfg_ready = aresetn;
    assign s_ready   = aresetn && (!m_valid_reg || m_ready);
    assign accept    = s_valid && s_ready;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign cfg_geom  = cfg_wr && ((cfg_index == doi_pkg::CFG_MAP_WIDTH)
                                  || (cfg_index == doi_pkg::CFG_MAP_HEIGHT)
                                  || (cfg_index == doi_pkg::CFG_INFLATE_RADIUS));

    // register writes, clamped to the supported range; the radius is taken from cfg_data[2:0] only
    always_comb begin
        w_next   = w_reg;
        h_next   = h_reg;
        r_next   = r_reg;
        lvl_next = lvl_reg;
        if (!aresetn) begin
            w_next   = WB'(W_RST);
            h_next   = HB'(H_RST);
            r_next   = RB'(R_RST);
            lvl_next = 8'(doi_pkg::RST_LEVEL);
        end else if (cfg_wr) begin
            unique case (cfg_index)
                doi_pkg::CFG_MAP_WIDTH: begin
                    if (cfg_data == '0) w_next = WB'(1);
                    else if (int'(cfg_data) > MAX_WIDTH) w_next = WB'(MAX_WIDTH);
                    else w_next = WB'(cfg_data);
                end
                doi_pkg::CFG_MAP_HEIGHT: begin
                    if (cfg_data == '0) h_next = HB'(1);
                    else if (int'(cfg_data) > MAX_HEIGHT) h_next = HB'(MAX_HEIGHT);
                    else h_next = HB'(cfg_data);
                end
                doi_pkg::CFG_INFLATE_RADIUS: begin
                    if (int'(cfg_data[2:0]) > MAX_RADIUS) r_next = RB'(MAX_RADIUS);
                    else r_next = RB'(cfg_data[2:0]);
                end
                doi_pkg::CFG_INFLATE_LEVEL: begin
                    if (cfg_data[7:0] > doi_pkg::COST_INSCRIBED) begin
                        lvl_next = doi_pkg::COST_INSCRIBED;
                    end else begin
                        lvl_next = cfg_data[7:0];
                    end
                end
                default: ;
            endcase
        end
        delay_next = DB'(r_next) * DB'(w_next) + DB'(r_next);
    end

    // write and result decisions
    always_comb begin
        wr_en = accept && (s_data.cmd == doi_pkg::CMD_CELL) && (in_row_reg < h_reg);
        if (s_data.cmd == doi_pkg::CMD_CELL) begin
            emit = wr_en && (QB'(out_cnt_reg) + QB'(delay_reg) <= QB'(rcv_reg));
        end else begin
            emit = accept && (out_cnt_reg < rcv_reg);
        end
        last  = (out_row_reg == h_reg - HB'(1)) && (WB'(out_col_reg) + WB'(1) == w_reg);
        clear = !aresetn || cfg_geom || (emit && last);
    end

    // input position after the current word
    always_comb begin
        in_col_adv  = in_col_reg;
        in_row_adv  = in_row_reg;
        in_slot_adv = in_slot_reg;
        if (wr_en) begin
            if (WB'(in_col_reg) + WB'(1) == w_reg) begin
                in_col_adv = '0;
                in_row_adv = in_row_reg + HB'(1);
                in_slot_adv = (int'(in_slot_reg) == NS-1) ? '0 : in_slot_reg + SB'(1);
            end else begin
                in_col_adv = in_col_reg + CB'(1);
            end
        end
        rcv_next = wr_en ? rcv_reg + PB'(1) : rcv_reg;
        in_col_next  = in_col_adv;
        in_row_next  = in_row_adv;
        in_slot_next = in_slot_adv;
        if (clear) begin
            in_col_next  = '0;
            in_row_next  = '0;
            in_slot_next = '0;
            rcv_next     = '0;
        end
    end

    // output position
    always_comb begin
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        out_slot_next = out_slot_reg;
        out_cnt_next  = out_cnt_reg;
        if (clear) begin
            out_col_next  = '0;
            out_row_next  = '0;
            out_slot_next = '0;
            out_cnt_next  = '0;
        end else if (emit) begin
            out_cnt_next = out_cnt_reg + PB'(1);
            if (WB'(out_col_reg) + WB'(1) == w_reg) begin
                out_col_next = '0;
                out_row_next = out_row_reg + HB'(1);
                out_slot_next = (int'(out_slot_reg) == NS-1) ? '0 : out_slot_reg + SB'(1);
            end else begin
                out_col_next = out_col_reg + CB'(1);
            end
        end
    end

    // inflated cost of the oldest pending cell
    always_comb begin
        if (wr_en && (rcv_reg == out_cnt_reg)) cost_p = s_data.cell_cost;
        else cost_p = cost_q;
        if (cost_p == doi_pkg::COST_LETHAL || !hit) begin
            result = cost_p;
        end else if (cost_p == doi_pkg::COST_UNKNOWN && lvl_reg >= doi_pkg::COST_INSCRIBED) begin
            result = lvl_reg;
        end else begin
            result = (cost_p > lvl_reg) ? cost_p : lvl_reg;
        end
    end

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next.out_cost   = result;
            m_data_next.frame_last = last;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        w_reg        <= w_next;
        h_reg        <= h_next;
        r_reg        <= r_next;
        lvl_reg      <= lvl_next;
        delay_reg    <= delay_next;
        in_col_reg   <= in_col_next;
        in_row_reg   <= in_row_next;
        in_slot_reg  <= in_slot_next;
        rcv_reg      <= rcv_next;
        out_col_reg  <= out_col_next;
        out_row_reg  <= out_row_next;
        out_slot_reg <= out_slot_next;
        out_cnt_reg  <= out_cnt_next;
        m_data_reg   <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    doi_line_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_RADIUS(MAX_RADIUS)
    ) u_store (
        .aclk     (aclk),
        .wr_en    (wr_en),
        .wr_col   (in_col_reg),
        .wr_slot  (in_slot_reg),
        .wr_lethal(s_data.cell_cost == doi_pkg::COST_LETHAL),
        .wr_cost  (s_data.cell_cost),
        .lr_col   (rd_col),
        .pf_word  (pf_word),
        .cr_slot  (out_slot_next),
        .cr_col   (out_col_next),
        .cost_q   (cost_q)
    );

    doi_window #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .MAX_RADIUS(MAX_RADIUS)
    ) u_window (
        .aclk     (aclk),
        .clear    (clear),
        .emit     (emit),
        .w_init   (w_next),
        .w        (w_reg),
        .h        (h_reg),
        .r        (r_reg),
        .wr_en    (wr_en),
        .wr_col   (in_col_reg),
        .wr_slot  (in_slot_reg),
        .wr_lethal(s_data.cell_cost == doi_pkg::COST_LETHAL),
        .pf_word  (pf_word),
        .out_col  (out_col_reg),
        .out_row  (out_row_reg),
        .out_slot (out_slot_reg),
        .rin      (in_row_adv),
        .rcol     (in_col_adv),
        .hit      (hit),
        .rd_col   (rd_col)
    );
endmodule
`default_nettype wire

// File: hdl/doi_line_store.sv
// Line store: per-column lethal bit words and raw cost ring, with read bypass.
`default_nettype none
module doi_line_store #(
    parameter int MAX_WIDTH  = doi_pkg::DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = doi_pkg::DEF_MAX_RADIUS
) (
    input  wire logic                                  aclk,
    input  wire logic                                  wr_en,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]          wr_col,
    input  wire logic [$clog2(2*MAX_RADIUS+2)-1:0]     wr_slot,
    input  wire logic                                  wr_lethal,
    input  wire logic [7:0]                            wr_cost,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]          lr_col,
    output logic      [2*MAX_RADIUS+1:0]               pf_word,
    input  wire logic [$clog2(2*MAX_RADIUS+2)-1:0]     cr_slot,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]          cr_col,
    output logic      [7:0]                            cost_q
);
    localparam int NS  = 2*MAX_RADIUS+2;
    localparam int SB  = $clog2(NS);
    localparam int CAW = $clog2(NS*MAX_WIDTH);

    logic [NS-1:0] leth_mem [MAX_WIDTH];
    logic [7:0]    cost_mem [NS*MAX_WIDTH];

    logic [NS-1:0] lq_reg;
    logic          lbyp_hit_reg;
    logic [SB-1:0] lbyp_slot_reg;
    logic          lbyp_bit_reg;
    logic [7:0]    cq_reg;
    logic          cbyp_hit_reg;
    logic [7:0]    cbyp_val_reg;
    logic [CAW-1:0] wa, ra;

    // ring address: slot row times row length plus column
    assign wa = CAW'(wr_slot) * CAW'(MAX_WIDTH) + CAW'(wr_col);
    assign ra = CAW'(cr_slot) * CAW'(MAX_WIDTH) + CAW'(cr_col);

    // lethal words, one bit per row slot
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            leth_mem[wr_col][wr_slot] <= wr_lethal;
        end
        lq_reg        <= leth_mem[lr_col];
        lbyp_hit_reg  <= wr_en && (wr_col == lr_col);
        lbyp_slot_reg <= wr_slot;
        lbyp_bit_reg  <= wr_lethal;
    end

    // raw cost ring
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            cost_mem[wa] <= wr_cost;
        end
        cq_reg       <= cost_mem[ra];
        cbyp_hit_reg <= wr_en && (wa == ra);
        cbyp_val_reg <= wr_cost;
    end

    // merge a write that raced the read
    always_comb begin
        pf_word = lq_reg;
        if (lbyp_hit_reg) begin
            pf_word[lbyp_slot_reg] = lbyp_bit_reg;
        end
    end

    assign cost_q = cbyp_hit_reg ? cbyp_val_reg : cq_reg;
endmodule
`default_nettype wire

// File: hdl/doi_window.sv
// Column window around the output cell and the disc lethal-hit test.
`default_nettype none
module doi_window #(
    parameter int MAX_WIDTH  = doi_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = doi_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = doi_pkg::DEF_MAX_RADIUS
) (
    input  wire logic                                  aclk,
    input  wire logic                                  clear,
    input  wire logic                                  emit,
    input  wire logic [$clog2(MAX_WIDTH+1)-1:0]        w_init,
    input  wire logic [$clog2(MAX_WIDTH+1)-1:0]        w,
    input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]       h,
    input  wire logic [$clog2(MAX_RADIUS+1)-1:0]       r,
    input  wire logic                                  wr_en,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]          wr_col,
    input  wire logic [$clog2(2*MAX_RADIUS+2)-1:0]     wr_slot,
    input  wire logic                                  wr_lethal,
    input  wire logic [2*MAX_RADIUS+1:0]               pf_word,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]          out_col,
    input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]       out_row,
    input  wire logic [$clog2(2*MAX_RADIUS+2)-1:0]     out_slot,
    input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]       rin,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]          rcol,
    output logic                                       hit,
    output logic      [$clog2(MAX_WIDTH)-1:0]          rd_col
);
    localparam int MR   = MAX_RADIUS;
    localparam int NS   = 2*MR+2;
    localparam int NWIN = 2*MR+1;
    localparam int CB   = $clog2(MAX_WIDTH);
    localparam int WB   = $clog2(MAX_WIDTH+1);
    localparam int SB   = $clog2(NS);

    logic [NS-1:0] win_word_reg [NWIN];
    logic [CB-1:0] win_tag_reg  [NWIN];
    logic [CB-1:0] la_col_reg;
    logic [CB-1:0] la_col_inc;
    logic [CB-1:0] init_col [MR+2];
    logic [NS-1:0] cur_f [NWIN];

    function automatic logic [NS-1:0] fwd(input logic [NS-1:0] word,
                                          input logic [CB-1:0] tag,
                                          input logic en,
                                          input logic [CB-1:0] col,
                                          input logic [SB-1:0] slot,
                                          input logic bitv);
        logic [NS-1:0] res;
        res = word;
        if (en && (tag == col)) begin
            res[slot] = bitv;
        end
        return res;
    endfunction

    // columns of the first cells of a frame
    always_comb begin
        init_col[0] = '0;
        for (int k = 1; k < MR+2; k++) begin
            if (WB'(init_col[k-1]) + WB'(1) == w_init) begin
                init_col[k] = '0;
            end else begin
                init_col[k] = init_col[k-1] + CB'(1);
            end
        end
    end

    // lookahead column and prefetch address
    always_comb begin
        if (WB'(la_col_reg) + WB'(1) == w) begin
            la_col_inc = '0;
        end else begin
            la_col_inc = la_col_reg + CB'(1);
        end
        if (clear) begin
            rd_col = init_col[MR+1];
        end else if (emit) begin
            rd_col = la_col_inc;
        end else begin
            rd_col = la_col_reg;
        end
    end

    // shift window on each result, forwarding the current write
    always_ff @(posedge aclk) begin
        la_col_reg <= rd_col;
        for (int i = 0; i < NWIN-1; i++) begin
            if (emit) begin
                win_word_reg[i] <= cur_f[i+1];
            end else begin
                win_word_reg[i] <= cur_f[i];
            end
        end
        if (emit) begin
            win_word_reg[NWIN-1] <= fwd(pf_word, la_col_reg, wr_en, wr_col, wr_slot,
                                        wr_lethal);
        end else begin
            win_word_reg[NWIN-1] <= cur_f[NWIN-1];
        end
        if (clear) begin
            for (int i = 0; i < MR; i++) begin
                win_tag_reg[i] <= '0;
            end
            for (int i = MR; i < NWIN; i++) begin
                win_tag_reg[i] <= init_col[i-MR];
            end
        end else if (emit) begin
            for (int i = 0; i < NWIN-1; i++) begin
                win_tag_reg[i] <= win_tag_reg[i+1];
            end
            win_tag_reg[NWIN-1] <= la_col_reg;
        end
    end

    // disc test over the window
    always_comb begin
        int rr, cc, t, dsq, rsq;
        logic row_ok, full_row, part_row, col_ok, col_lt;
        logic [SB-1:0] sel;
        hit = 1'b0;
        rsq = int'(r) * int'(r);
        for (int i = 0; i < NWIN; i++) begin
            cur_f[i] = fwd(win_word_reg[i], win_tag_reg[i], wr_en, wr_col, wr_slot, wr_lethal);
        end
        for (int j = 0; j < NWIN; j++) begin
            rr = int'(out_row) + j - MR;
            row_ok = (rr >= 0) && (rr < int'(h));
            full_row = rr < int'(rin);
            part_row = rr == int'(rin);
            t = int'(out_slot) + j - MR;
            if (t < 0) begin
                t = t + NS;
            end else if (t >= NS) begin
                t = t - NS;
            end
            sel = SB'(t);
            for (int i = 0; i < NWIN; i++) begin
                cc = int'(out_col) + i - MR;
                col_ok = (cc >= 0) && (cc < int'(w));
                col_lt = cc < int'(rcol);
                dsq = (i-MR)*(i-MR) + (j-MR)*(j-MR);
                if ((dsq <= rsq) && row_ok && col_ok && (full_row || (part_row && col_lt))
                    && cur_f[i][sel]) begin
                    hit = 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire
